/* rtl/rgbpb_pkg.sv */
// ----------------------------------------------------------------------------
// rgbpb_pkg
// shared types and constants of the rgb16 pixel blend unit
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpb_pkg;

  // blend operations
  typedef enum logic [2:0] {
    OP_ALPHA = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MAX   = 3'd3,
    OP_GRAY  = 3'd4
  } opcode_e;

  // configuration register indexes
  localparam logic CFG_PIXEL_FORMAT = 1'b0;
  localparam logic CFG_TINT_SHIFT   = 1'b1;

  localparam int unsigned CfgDataWidth = 4;

  // pixel_format codes
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB555 = 1'b1;

  localparam logic [5:0] ChanTop5  = 6'd31;
  localparam logic [5:0] ChanTop6  = 6'd63;
  localparam logic [7:0] AlphaFull = 8'd32;

  // divide by ten as multiply by 205 and shift by 11, exact below 1029
  localparam logic [7:0] Recip10 = 8'd205;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] src_pix;
    logic [15:0] dst_pixel;
    logic [7:0]  alpha;
  } rgbpb_in_t;

  typedef struct packed {
    logic [15:0] out_pixel;
    logic        written;
  } rgbpb_out_t;

  typedef struct packed {
    logic       pixel_format;
    logic [3:0] tint_shift;
  } rgbpb_cfg_t;

endpackage : rgbpb_pkg

`default_nettype wire

/* rtl/rgb16_pixel_blend_unit.sv */
// pipeline: an accepted item is held in the input register, its result in the result register
// throughput: one item per cycle while the output is not stalled, set by the input register feeding the blend
//   datapath and the result register behind it
// reset: pipeline valids cleared, pixel_format = RGB565, tint_shift = 0
// ----------------------------------------------------------------------------
// rgb16_pixel_blend_unit
// blends a source pixel into a destination pixel, or writes a gray tint, in RGB565 or RGB555
// ----------------------------------------------------------------------------
`default_nettype none

module rgb16_pixel_blend_unit
  import rgbpb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input item channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire rgbpb_in_t               in_data_i,
  // result item channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output rgbpb_out_t                   out_data_o,
  // configuration writes
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i
);

  // configuration registers
  rgbpb_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= FMT_RGB565;
      cfg_q.tint_shift   <= 4'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PIXEL_FORMAT) begin
        cfg_q.pixel_format <= cfg_wdata_i[0];
      end else begin
        cfg_q.tint_shift <= cfg_wdata_i[3:0];
      end
    end
  end

  // stage 1: input register
  logic      s1_valid_q;
  rgbpb_in_t s1_q;
  // stage 2: result register
  logic       s2_valid_q;
  rgbpb_out_t s2_q;
  rgbpb_out_t s2_d;

  logic s2_stall;
  logic s1_stall;
  logic in_take;
  logic s2_load;

  // a stage holds only when it is full and the stage after it holds too
  assign s2_stall = s2_valid_q && out_stall_i;
  assign s1_stall = s1_valid_q && s2_stall;
  assign in_take  = in_valid_i && !s1_stall;
  assign s2_load  = s1_valid_q && !s2_stall;

  assign in_stall_o = s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
  end

  // blend datapath between the two registers
  rgbpb_core u_core (
    .item_i   (s1_q),
    .cfg_i    (cfg_q),
    .result_o (s2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_stall) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

  // an accepted item always lands in the input register
  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted item lost before stage 1");

  // an item leaving stage 1 always shows up as a result
  a_load_fills_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("stage 1 item lost before result register");

  // a transparent source never marks the destination written
  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && (s1_q.src_pix == 16'd0)) |=> !out_data_o.written)
    else $error("transparent pixel marked written");

  // channel modes in RGB555 leave the top bit clear
  a_555_top_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && (cfg_q.pixel_format == FMT_RGB555) && (s1_q.src_pix != 16'd0) &&
     ((s1_q.opcode == OP_ALPHA) || (s1_q.opcode == OP_ADD) ||
      (s1_q.opcode == OP_SUB) || (s1_q.opcode == OP_MAX)))
    |=> !out_data_o.out_pixel[15])
    else $error("RGB555 result has bit 15 set");

endmodule : rgb16_pixel_blend_unit

`default_nettype wire

/* rtl/rgbpb_core.sv */
// ----------------------------------------------------------------------------
// rgbpb_core
// combinational blend datapath for one pixel item
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpb_core
  import rgbpb_pkg::*;
(
  input  wire rgbpb_in_t  item_i,
  input  wire rgbpb_cfg_t cfg_i,
  output rgbpb_out_t      result_o
);

  // floor((s - d) * a / 32) + d
  function automatic logic [5:0] blend_ch(input logic [5:0] s, input logic [5:0] d,
                                          input logic [5:0] a);
    logic signed [7:0]  diff;
    logic signed [14:0] prod;
    logic signed [14:0] shr;
    logic [7:0]         sum;
    diff = $signed({2'b00, s}) - $signed({2'b00, d});
    prod = $signed({{7{diff[7]}}, diff}) * $signed({9'b0, a});
    shr  = prod >>> 5;
    sum  = shr[7:0] + {2'b00, d};
    return sum[5:0];
  endfunction

  function automatic logic [5:0] sat_add(input logic [5:0] x, input logic [5:0] y,
                                         input logic [5:0] top);
    logic [6:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return (sum > {1'b0, top}) ? top : sum[5:0];
  endfunction

  logic        fmt555;
  logic [5:0]  a_sat;
  logic [5:0]  sr, sg, sb, dr, dg, db;
  logic [5:0]  rr, rg, rb;
  logic [5:0]  gtop;
  logic [15:0] packed_pix;
  logic [9:0]  gsum;
  logic [17:0] gprod;
  logic [5:0]  gray;
  logic [15:0] red_sh;
  logic [15:0] tint_pix;
  logic [15:0] grn_part;
  logic        active;

  assign fmt555 = (cfg_i.pixel_format == FMT_RGB555);
  assign a_sat  = (item_i.alpha > AlphaFull) ? AlphaFull[5:0] : item_i.alpha[5:0];
  assign gtop   = fmt555 ? ChanTop5 : ChanTop6;

  // channel unpack
  always_comb begin
    if (fmt555) begin
      sr = {1'b0, item_i.src_pix[14:10]};
      sg = {1'b0, item_i.src_pix[9:5]};
      dr = {1'b0, item_i.dst_pixel[14:10]};
      dg = {1'b0, item_i.dst_pixel[9:5]};
    end else begin
      sr = {1'b0, item_i.src_pix[15:11]};
      sg = item_i.src_pix[10:5];
      dr = {1'b0, item_i.dst_pixel[15:11]};
      dg = item_i.dst_pixel[10:5];
    end
    sb = {1'b0, item_i.src_pix[4:0]};
    db = {1'b0, item_i.dst_pixel[4:0]};
  end

  // per-channel modes
  always_comb begin
    case (item_i.opcode)
      OP_ALPHA: begin
        rr = blend_ch(sr, dr, a_sat);
        rg = blend_ch(sg, dg, a_sat);
        rb = blend_ch(sb, db, a_sat);
      end
      OP_ADD: begin
        rr = sat_add(sr, dr, ChanTop5);
        rg = sat_add(sg, dg, gtop);
        rb = sat_add(sb, db, ChanTop5);
      end
      OP_SUB: begin
        rr = (dr > sr) ? dr - sr : 6'd0;
        rg = (dg > sg) ? dg - sg : 6'd0;
        rb = (db > sb) ? db - sb : 6'd0;
      end
      default: begin
        rr = (sr > dr) ? sr : dr;
        rg = (sg > dg) ? sg : dg;
        rb = (sb > db) ? sb : db;
      end
    endcase
  end

  always_comb begin
    if (fmt555) begin
      packed_pix = {1'b0, rr[4:0], 10'b0} | {5'b0, rg, 5'b0} | {11'b0, rb[4:0]};
    end else begin
      packed_pix = {rr[4:0], 11'b0} | {5'b0, rg, 5'b0} | {11'b0, rb[4:0]};
    end
  end

  // gray tint, parts ORed unmasked and cut to 16 bits
  assign gsum  = ({3'b0, sr, 1'b0} + {4'b0, sr}) +
                 ({2'b0, sg, 2'b00} + {3'b0, sg, 1'b0}) + {4'b0, sb};
  assign gprod = {8'b0, gsum} * {10'b0, Recip10};
  assign gray  = gprod[16:11];
  assign red_sh = 16'({10'b0, gray} << cfg_i.tint_shift);

  always_comb begin
    if (fmt555) begin
      grn_part = {({gray, 5'b0} | {5'b0, gray}), 5'b0};
      tint_pix = {red_sh[5:0], 10'b0} | grn_part | {10'b0, gray};
    end else begin
      grn_part = 16'({({gray, 6'b0} | {6'b0, gray}), 5'b0});
      tint_pix = {red_sh[4:0], 11'b0} | grn_part | {10'b0, gray};
    end
  end

  assign active = (item_i.src_pix != 16'd0) &&
                  ((item_i.opcode == OP_ALPHA) || (item_i.opcode == OP_ADD) ||
                   (item_i.opcode == OP_SUB) || (item_i.opcode == OP_MAX) ||
                   (item_i.opcode == OP_GRAY));

  always_comb begin
    if (!active) begin
      result_o.out_pixel = item_i.dst_pixel;
      result_o.written   = 1'b0;
    end else if (item_i.opcode == OP_GRAY) begin
      result_o.out_pixel = tint_pix;
      result_o.written   = 1'b1;
    end else begin
      result_o.out_pixel = packed_pix;
      result_o.written   = 1'b1;
    end
  end

endmodule : rgbpb_core

`default_nettype wire
